/* rtl/core/lru_k_frame_replacer_assert.svh */
// Assertion macros shared by the frame replacer RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef LRU_K_FRAME_REPLACER_ASSERT_SVH
`define LRU_K_FRAME_REPLACER_ASSERT_SVH

// same-cycle implication
`define LKFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LKFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lkfr_pkg.sv */
// Shared types and constants of the LRU-K frame replacer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lkfr_pkg;

  localparam int FRAME_COUNT_DEF = 64;
  localparam int CLOCK_WIDTH_DEF = 32;
  localparam int IDX_W_MAX       = 10;  // frame index width at the largest frame count
  localparam int FRAME_W         = 6;
  localparam int DEPTH_W         = 4;
  localparam int FIU_W           = 7;
  localparam int COUNT_OUT_W     = 7;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 7;

  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_SET_EV = 2'd1,
    OP_REMOVE = 2'd2,
    OP_EVICT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_RANGE  = 2'd1,
    ERR_PINNED = 2'd2
  } err_e;

  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_DEPTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 2'd1;

  // broadcast write to the cell row
  typedef struct packed {
    logic                 access;
    logic                 set_ev;
    logic                 remove;
    logic                 evict_clr;
    logic                 ev_val;
    logic [IDX_W_MAX-1:0] frame;
  } cmd_t;

  typedef struct packed {
    logic present;
    logic evictable;
  } status_t;

endpackage
`default_nettype wire

/* rtl/core/lkfr_cell.sv */
// One frame of the replacer: its history state plus one stage of the victim search chain.
// Depends on lkfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lkfr_cell #(
  parameter int FRAME_COUNT = lkfr_pkg::FRAME_COUNT_DEF,
  parameter int CLOCK_WIDTH = lkfr_pkg::CLOCK_WIDTH_DEF,
  parameter int INDEX       = 0,
  localparam int IW         = $clog2(FRAME_COUNT)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lkfr_pkg::cmd_t          cmd_i,
  input  wire logic [lkfr_pkg::DEPTH_W-1:0] depth_i,
  input  wire logic [CLOCK_WIDTH-1:0]  clock_i,
  input  wire logic [CLOCK_WIDTH-1:0]  stamp_i,
  input  wire logic                    in_valid_i,
  input  wire logic                    in_hist_i,
  input  wire logic [CLOCK_WIDTH-1:0]  in_age_i,
  input  wire logic [IW-1:0]           in_idx_i,
  output logic                         out_valid_o,
  output logic                         out_hist_o,
  output logic [CLOCK_WIDTH-1:0]       out_age_o,
  output logic [IW-1:0]                out_idx_o,
  output lkfr_pkg::status_t            status_o
);
  import lkfr_pkg::*;

  logic                        present_q, present_d;
  logic                        ev_q, ev_d;
  logic [DEPTH_W-1:0]          cnt_q, cnt_d;
  logic [CLOCK_WIDTH-1:0]      last_q, last_d;
  logic                        hit;
  logic [DEPTH_W-1:0]          base_cnt;
  logic                        elig, own_hist, better;
  logic [CLOCK_WIDTH-1:0]      own_age;

  assign hit      = (cmd_i.frame == IDX_W_MAX'(INDEX));
  assign base_cnt = present_q ? cnt_q : '0;

  always_comb begin
    present_d = present_q;
    ev_d      = ev_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    if (hit && cmd_i.access) begin
      // absent frame comes back with a fresh history
      present_d = 1'b1;
      ev_d      = present_q ? ev_q : 1'b0;
      cnt_d     = (base_cnt < depth_i) ? base_cnt + DEPTH_W'(1) : base_cnt;
      last_d    = stamp_i;
    end else if (hit && cmd_i.set_ev && present_q) begin
      ev_d = cmd_i.ev_val;
    end else if (hit && cmd_i.remove) begin
      present_d = 1'b0;
      ev_d      = 1'b0;
      cnt_d     = '0;
    end else if (hit && cmd_i.evict_clr) begin
      ev_d  = 1'b0;
      cnt_d = '0;
    end
  end

  // history group outranks buffer group; ties keep the lower frame from upstream
  assign elig     = present_q && ev_q && (cnt_q != '0);
  assign own_hist = (cnt_q < depth_i);
  assign own_age  = clock_i - last_q;
  assign better   = elig && (!in_valid_i || (own_hist && !in_hist_i) ||
                             ((own_hist == in_hist_i) && (own_age > in_age_i)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= 1'b1;
      ev_q        <= 1'b0;
      cnt_q       <= '0;
      last_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      present_q   <= present_d;
      ev_q        <= ev_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      out_valid_o <= better || in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hist_o <= better ? own_hist : in_hist_i;
    out_age_o  <= better ? own_age : in_age_i;
    out_idx_o  <= better ? IW'(INDEX) : in_idx_i;
  end

  assign status_o.present   = present_q;
  assign status_o.evictable = ev_q;

endmodule
`default_nettype wire

/* rtl/core/lru_k_frame_replacer.sv */
// Top level of the LRU-K frame replacer: command sequencer, counters and the cell row.
// Depends on lkfr_pkg, lkfr_cell and lru_k_frame_replacer_assert.svh.
//
//  channel  | handshake              | fields
//  command  | start / busy           | opcode_i, frame_i, evictable_value_i
//  result   | done_o (one cycle)     | victim_found_o, victim_frame_o, error_code_o,
//           |                        | evictable_count_o
//  config   | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Access, set evictable and remove: start leads to the decide state, which registers the result.
// Evict: the victim search ripples one cell per cycle down the row while the sequencer waits
// in the search state. Reset sets every frame present with no history; no clearing pass.
// Results are strobed once and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_k_frame_replacer_assert.svh"
module lru_k_frame_replacer #(
  parameter int FRAME_COUNT = lkfr_pkg::FRAME_COUNT_DEF,
  parameter int CLOCK_WIDTH = lkfr_pkg::CLOCK_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       opcode_i,
  input  wire logic [lkfr_pkg::FRAME_W-1:0]     frame_i,
  input  wire logic                             evictable_value_i,
  output logic                                  done_o,
  output logic                                  victim_found_o,
  output logic [lkfr_pkg::FRAME_W-1:0]          victim_frame_o,
  output logic [1:0]                            error_code_o,
  output logic [lkfr_pkg::COUNT_OUT_W-1:0]      evictable_count_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [lkfr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [lkfr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import lkfr_pkg::*;

  localparam int IW = $clog2(FRAME_COUNT);
  localparam int TW = ($clog2(FRAME_COUNT + 1) > COUNT_OUT_W) ?
                      $clog2(FRAME_COUNT + 1) : COUNT_OUT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  state_e                 state_q;
  op_e                    op_q;
  logic [FRAME_W-1:0]     frame_q;
  logic                   evv_q;
  logic [DEPTH_W-1:0]     depth_q;
  logic [FIU_W-1:0]       fiu_q;
  logic [CLOCK_WIDTH-1:0] clock_q, clock_d;
  logic [TW-1:0]          total_q, total_d;
  logic [IW-1:0]          wait_q;
  logic                   found;
  err_e                   err_d;
  cmd_t                   cmd;
  logic [DEPTH_W-1:0]     k_eff;
  logic                   in_range;
  status_t                tgt;

  status_t                status [FRAME_COUNT];
  logic                   c_valid [FRAME_COUNT+1];
  logic                   c_hist  [FRAME_COUNT+1];
  logic [CLOCK_WIDTH-1:0] c_age   [FRAME_COUNT+1];
  logic [IW-1:0]          c_idx   [FRAME_COUNT+1];

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign k_eff       = (depth_q == '0) ? DEPTH_W'(1) : depth_q;
  assign in_range    = (frame_q < fiu_q) && (int'(frame_q) < FRAME_COUNT);
  assign tgt         = status[IW'(frame_q)];
  assign found       = c_valid[FRAME_COUNT] && (total_q != '0);

  assign c_valid[0] = 1'b0;
  assign c_hist[0]  = 1'b0;
  assign c_age[0]   = '0;
  assign c_idx[0]   = '0;

  for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
    lkfr_cell #(
      .FRAME_COUNT(FRAME_COUNT),
      .CLOCK_WIDTH(CLOCK_WIDTH),
      .INDEX      (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .depth_i    (k_eff),
      .clock_i    (clock_q),
      .stamp_i    (clock_d),
      .in_valid_i (c_valid[g]),
      .in_hist_i  (c_hist[g]),
      .in_age_i   (c_age[g]),
      .in_idx_i   (c_idx[g]),
      .out_valid_o(c_valid[g+1]),
      .out_hist_o (c_hist[g+1]),
      .out_age_o  (c_age[g+1]),
      .out_idx_o  (c_idx[g+1]),
      .status_o   (status[g])
    );
  end

  always_comb begin
    cmd       = '0;
    clock_d   = clock_q;
    total_d   = total_q;
    err_d     = ERR_NONE;
    cmd.frame = IDX_W_MAX'(frame_q);
    cmd.ev_val = evv_q;
    if (state_q == ST_DECIDE) begin
      case (op_q)
        OP_ACCESS: begin
          clock_d    = clock_q + CLOCK_WIDTH'(1);
          cmd.access = in_range;
          if (!in_range) err_d = ERR_RANGE;
        end
        OP_SET_EV: begin
          cmd.set_ev = in_range;
          if (!in_range) begin
            err_d = ERR_RANGE;
          end else if (tgt.present && (tgt.evictable != evv_q)) begin
            if (evv_q) total_d = total_q + TW'(1);
            else if (total_q != '0) total_d = total_q - TW'(1);
          end
        end
        OP_REMOVE: begin
          if (!in_range) begin
            err_d = ERR_RANGE;
          end else if (tgt.present && !tgt.evictable) begin
            err_d = ERR_PINNED;
          end else if (tgt.present) begin
            cmd.remove = 1'b1;
            if (total_q != '0) total_d = total_q - TW'(1);
          end
        end
        default: ;
      endcase
    end else if (state_q == ST_FINISH) begin
      cmd.frame     = IDX_W_MAX'(c_idx[FRAME_COUNT]);
      cmd.evict_clr = found;
      if (found) total_d = total_q - TW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      op_q              <= OP_ACCESS;
      frame_q           <= '0;
      evv_q             <= 1'b0;
      depth_q           <= DEPTH_W'(2);
      fiu_q             <= FIU_W'(64);
      clock_q           <= '0;
      total_q           <= '0;
      wait_q            <= '0;
      done_o            <= 1'b0;
      victim_found_o    <= 1'b0;
      victim_frame_o    <= '0;
      error_code_o      <= ERR_NONE;
      evictable_count_o <= '0;
    end else begin
      done_o  <= 1'b0;
      clock_q <= clock_d;
      total_q <= total_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_HISTORY_DEPTH) depth_q <= cfg_data_i[DEPTH_W-1:0];
        else if (cfg_index_i == REG_FRAMES_IN_USE) fiu_q <= cfg_data_i[FIU_W-1:0];
      end
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            op_q    <= op_e'(opcode_i);
            frame_q <= frame_i;
            evv_q   <= evictable_value_i;
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (op_q == OP_EVICT) begin
            wait_q  <= '0;
            state_q <= ST_SEARCH;
          end else begin
            done_o            <= 1'b1;
            victim_found_o    <= 1'b0;
            victim_frame_o    <= '0;
            error_code_o      <= err_d;
            evictable_count_o <= total_d[COUNT_OUT_W-1:0];
            state_q           <= ST_IDLE;
          end
        end
        ST_SEARCH: begin
          // row state is frozen; wait until the chain tail has seen every cell
          wait_q <= wait_q + IW'(1);
          if (wait_q == IW'(FRAME_COUNT - 1)) state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          done_o            <= 1'b1;
          victim_found_o    <= found;
          victim_frame_o    <= found ? FRAME_W'(c_idx[FRAME_COUNT]) : '0;
          error_code_o      <= ERR_NONE;
          evictable_count_o <= total_d[COUNT_OUT_W-1:0];
          state_q           <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `LKFR_ASSERT_NEXT(a_start_decides, start && !busy, state_q == ST_DECIDE, "start not taken")
  `LKFR_ASSERT_NOW(a_victim_no_err, done_o && victim_found_o, error_code_o == ERR_NONE,
    "victim reported with error")
  `LKFR_ASSERT_NOW(a_total_bound, 1'b1, total_q <= TW'(FRAME_COUNT), "evictable total overflow")
  `LKFR_ASSERT_NEXT(a_search_ends, state_q == ST_SEARCH && wait_q == IW'(FRAME_COUNT - 1),
    state_q == ST_FINISH, "search overran")

endmodule
`default_nettype wire

/* tb/lru_k_frame_replacer_tb.sv */
// Self-checking testbench for lru_k_frame_replacer: an in-bench LRU-K predictor checks each word.
// It runs directed and random command streams with random idle gaps over several register settings.
// Depends on lkfr_pkg and the lru_k_frame_replacer RTL.
`timescale 1ns / 1ps
module lru_k_frame_replacer_tb;
  import lkfr_pkg::*;

  localparam int NFRAMES   = 64;
  localparam int SETTLE    = NFRAMES + 16;
  localparam int WDOG_MAX  = 4000;

  typedef struct {
    op_e        op;
    logic [5:0] frame;
    logic       ev;
  } cmd_word_t;

  typedef struct {
    logic       found;
    logic [5:0] victim;
    err_e       err;
    logic [6:0] ev_count;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] opcode_i = '0;
  logic [FRAME_W-1:0] frame_i = '0;
  logic evictable_value_i = 1'b0;
  logic done_o, victim_found_o;
  logic [FRAME_W-1:0] victim_frame_o;
  logic [1:0] error_code_o;
  logic [COUNT_OUT_W-1:0] evictable_count_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  lru_k_frame_replacer DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [3:0]  depth_reg = 4'd2;
  logic [6:0]  fiu_reg = 7'd64;
  logic        present_q[NFRAMES];
  logic        evict_q[NFRAMES];
  logic [3:0]  hits_q[NFRAMES];
  logic [31:0] stamp_q[NFRAMES];
  logic [31:0] tick_q = '0;
  logic [6:0]  ev_total = '0;

  cmd_word_t cmd_q[$];
  outcome_t  expected_q[$];
  bit        idle_on = 1'b1;
  int        gap_cnt = 0;
  int        quiet_cycles = 0;
  bit        failed = 1'b0;

  initial begin
    for (int i = 0; i < NFRAMES; i++) begin
      present_q[i] = 1'b1;
      evict_q[i]   = 1'b0;
      hits_q[i]    = '0;
      stamp_q[i]   = '0;
    end
  end

  function automatic int oldest_frame(bit buffer_grp);
    int best = -1;
    logic [31:0] best_age = '0;
    logic [3:0] k = (depth_reg == 0) ? 4'd1 : depth_reg;
    logic [31:0] age;
    for (int f = 0; f < NFRAMES; f++) begin
      if (!present_q[f] || !evict_q[f] || hits_q[f] == 0) continue;
      if ((hits_q[f] >= k) != buffer_grp) continue;
      age = tick_q - stamp_q[f];
      if (best < 0 || age > best_age) begin
        best = f;
        best_age = age;
      end
    end
    return best;
  endfunction

  function automatic outcome_t predict_replacer(cmd_word_t c);
    outcome_t r;
    int v;
    bit in_range = c.frame < fiu_reg;
    logic [3:0] k = (depth_reg == 0) ? 4'd1 : depth_reg;
    int f = c.frame;
    r.found = 1'b0;
    r.victim = '0;
    r.err = ERR_NONE;
    case (c.op)
      OP_ACCESS: begin
        tick_q = tick_q + 1;
        if (!in_range) r.err = ERR_RANGE;
        else begin
          if (!present_q[f]) begin
            present_q[f] = 1'b1;
            evict_q[f] = 1'b0;
            hits_q[f] = '0;
          end
          if (hits_q[f] < k) hits_q[f] = hits_q[f] + 1;
          stamp_q[f] = tick_q;
        end
      end
      OP_SET_EV: begin
        if (!in_range) r.err = ERR_RANGE;
        else if (present_q[f] && evict_q[f] != c.ev) begin
          evict_q[f] = c.ev;
          if (c.ev) ev_total++;
          else if (ev_total > 0) ev_total--;
        end
      end
      OP_REMOVE: begin
        if (!in_range) r.err = ERR_RANGE;
        else if (present_q[f]) begin
          if (!evict_q[f]) r.err = ERR_PINNED;
          else begin
            present_q[f] = 1'b0;
            evict_q[f] = 1'b0;
            hits_q[f] = '0;
            if (ev_total > 0) ev_total--;
          end
        end
      end
      default: begin
        if (ev_total > 0) begin
          v = oldest_frame(1'b0);
          if (v < 0) v = oldest_frame(1'b1);
          if (v >= 0) begin
            r.found = 1'b1;
            r.victim = v[5:0];
            evict_q[v] = 1'b0;
            hits_q[v] = '0;
            ev_total--;
          end
        end
      end
    endcase
    r.ev_count = ev_total;
    return r;
  endfunction

  // command driver
  always @(posedge clk_i) begin
    cmd_word_t c;
    if (rst_ni) begin
      if (start && !busy) begin
        c.op = op_e'(opcode_i);
        c.frame = frame_i;
        c.ev = evictable_value_i;
        expected_q.push_back(predict_replacer(c));
        gap_cnt = idle_on ? $urandom_range(0, 15) : 0;
      end
      if (!(start && busy)) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          start <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          c = cmd_q.pop_front();
          opcode_i <= c.op;
          frame_i <= c.frame;
          evictable_value_i <= c.ev;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word: found=%0d victim=%0d err=%0d count=%0d", $time,
                 victim_found_o, victim_frame_o, error_code_o, evictable_count_o);
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        if (victim_found_o !== e.found) begin
          $display("%0t: victim_found exp %0d got %0d", $time, e.found, victim_found_o);
          failed = 1'b1;
        end
        if (victim_frame_o !== e.victim) begin
          $display("%0t: victim_frame exp %0d got %0d", $time, e.victim, victim_frame_o);
          failed = 1'b1;
        end
        if (error_code_o !== e.err) begin
          $display("%0t: error_code exp %0d got %0d", $time, e.err, error_code_o);
          failed = 1'b1;
        end
        if (evictable_count_o !== e.ev_count) begin
          $display("%0t: evictable_count exp %0d got %0d", $time, e.ev_count,
                   evictable_count_o);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog: cycles with no word moving on any channel
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_cmd(op_e op, int fr, bit ev);
    cmd_word_t c;
    c.op = op;
    c.frame = fr[5:0];
    c.ev = ev;
    cmd_q.push_back(c);
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_HISTORY_DEPTH) depth_reg = val[3:0];
    else fiu_reg = val[6:0];
  endtask

  task automatic random_cmds(int n);
    int r, hot, fr;
    op_e op;
    hot = (fiu_reg < 8) ? fiu_reg : 8;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 7 && hot > 0) fr = $urandom_range(0, hot - 1);
      else if (r < 9 || fiu_reg >= NFRAMES) fr = $urandom_range(0, 63);
      else fr = $urandom_range(fiu_reg, 63);
      r = $urandom_range(0, 9);
      op = (r < 4) ? OP_ACCESS : (r < 7) ? OP_SET_EV : (r < 8) ? OP_REMOVE : OP_EVICT;
      push_cmd(op, fr, $urandom_range(0, 1));
    end
  endtask

  initial begin
    int depths[6] = '{1, 15, 0, 3, 4, 15};
    int fius[6]   = '{64, 64, 10, 1, 64, 40};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, pinned and absent frames, no-history frame, empty evict
    push_cmd(OP_EVICT, 0, 0);
    push_cmd(OP_ACCESS, 0, 0);
    push_cmd(OP_ACCESS, 63, 1);
    push_cmd(OP_ACCESS, 63, 0);
    push_cmd(OP_SET_EV, 0, 1);
    push_cmd(OP_SET_EV, 63, 1);
    push_cmd(OP_SET_EV, 5, 1);
    push_cmd(OP_SET_EV, 5, 1);
    push_cmd(OP_REMOVE, 1, 0);
    push_cmd(OP_EVICT, 0, 0);
    push_cmd(OP_EVICT, 0, 0);
    push_cmd(OP_EVICT, 0, 0);
    push_cmd(OP_REMOVE, 5, 0);
    push_cmd(OP_SET_EV, 5, 1);
    push_cmd(OP_REMOVE, 5, 0);
    push_cmd(OP_ACCESS, 5, 0);
    push_cmd(OP_SET_EV, 5, 1);
    push_cmd(OP_SET_EV, 5, 0);
    push_cmd(OP_SET_EV, 5, 1);
    push_cmd(OP_EVICT, 63, 1);
    push_cmd(OP_EVICT, 0, 0);
    drain();
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_HISTORY_DEPTH, depths[p]);
      write_reg(REG_FRAMES_IN_USE, fius[p]);
      idle_on = (p % 3) != 1;
      random_cmds(205);
      drain();
    end
    if (!failed) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
